/* src/gpe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gpe_pkg;

    // register indexes on the configuration channel
    localparam int GPE_CFG_IW = 2;
    localparam logic [GPE_CFG_IW-1:0] GPE_REG_Z = 2'd0;
    localparam logic [GPE_CFG_IW-1:0] GPE_REG_H = 2'd1;
    localparam logic [GPE_CFG_IW-1:0] GPE_REG_D = 2'd2;

    localparam logic [31:0] GPE_LN2_Q32 = 32'hB172_17F8;
    localparam logic [63:0] GPE_DEFAULT_LIMIT = 64'd281474977;
    localparam int GPE_PHI_TOP = 13;   // highest Horner divisor
    localparam int GPE_TAB_N = 18;

    typedef logic [31:0] gpe_tab_t [GPE_TAB_N];

    localparam gpe_tab_t GPE_TAB_Z = '{
        32'd2, 32'd3, 32'd5, 32'd11, 32'd13, 32'd19, 32'd29, 32'd31, 32'd37,
        32'd47, 32'd49, 32'd55, 32'd70, 32'd79, 32'd81, 32'd87, 32'd102, 32'd113};
    localparam gpe_tab_t GPE_TAB_H5 = '{
        32'd1227500, 32'd324800, 32'd681200, 32'd300100, 32'd983700, 32'd555771,
        32'd250000, 32'd293200, 32'd479870, 32'd195883, 32'd336300, 32'd584600,
        32'd370000, 32'd453331, 32'd473540, 32'd617300, 32'd433716, 32'd510036};
    localparam gpe_tab_t GPE_TAB_D5 = '{
        32'd355200, 32'd251800, 32'd453500, 32'd103800, 32'd299813, 32'd165891,
        32'd65000, 32'd73600, 32'd106374, 32'd52759, 32'd75499, 32'd114500,
        32'd66000, 32'd73931, 32'd77490, 32'd96700, 32'd67213, 32'd75391};

    // interpolation setup: H = (h_lo*wl + h_hi*wh + span/2) / span, same for d
    typedef struct packed {
        logic [31:0] h_lo;
        logic [31:0] d_lo;
        logic [31:0] h_hi;
        logic [31:0] d_hi;
        logic [7:0]  wl;
        logic [7:0]  wh;
        logic [7:0]  span;
    } gpe_lookup_t;

    // derived parameters handed to the datapath
    typedef struct packed {
        logic        busy;
        logic        h_zero;
        logic        d_zero;
        logic        z_neg;
        logic [7:0]  z_mag;
        logic [31:0] d;
        logic [55:0] ratio;
    } gpe_params_t;

    // five-digit decimal to Q8.24, round half up (used on table constants only)
    function automatic logic [31:0] gpe_dec5_q24(input logic [31:0] v);
        logic [63:0] t;
        t = 64'(v) * 64'd16777216 + 64'd50000;
        return 32'(t / 64'd100000);
    endfunction

    function automatic gpe_lookup_t gpe_lookup(input logic [7:0] z);
        gpe_lookup_t r;
        r = '0;
        r.wl = 8'd1;
        r.span = 8'd1;
        if (z > 8'd113) begin
            r.h_lo = gpe_dec5_q24(32'd500000);
            r.d_lo = gpe_dec5_q24(32'd75000);
        end else begin
            for (int i = 0; i < GPE_TAB_N; i++) begin
                if (32'(z) == GPE_TAB_Z[i]) begin
                    r.h_lo = gpe_dec5_q24(GPE_TAB_H5[i]);
                    r.d_lo = gpe_dec5_q24(GPE_TAB_D5[i]);
                end
            end
            for (int i = 1; i < GPE_TAB_N; i++) begin
                if (32'(z) > GPE_TAB_Z[i-1] && 32'(z) < GPE_TAB_Z[i]) begin
                    r.h_lo = gpe_dec5_q24(GPE_TAB_H5[i-1]);
                    r.d_lo = gpe_dec5_q24(GPE_TAB_D5[i-1]);
                    r.h_hi = gpe_dec5_q24(GPE_TAB_H5[i]);
                    r.d_hi = gpe_dec5_q24(GPE_TAB_D5[i]);
                    r.wl   = 8'(GPE_TAB_Z[i] - 32'(z));
                    r.wh   = 8'(32'(z) - GPE_TAB_Z[i-1]);
                    r.span = 8'(GPE_TAB_Z[i] - GPE_TAB_Z[i-1]);
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/gpe_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gpe_in_if ();
    logic        valid;
    logic        ready;
    logic [31:0] radius;
    modport source (output valid, output radius, input ready);
    modport sink   (input valid, input radius, output ready);
endinterface

interface gpe_out_if ();
    logic        valid;
    logic        ready;
    logic [31:0] potential;
    logic        saturated;
    modport source (output valid, output potential, output saturated, input ready);
    modport sink   (input valid, input potential, input saturated, output ready);
endinterface

interface gpe_cfg_if import gpe_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [GPE_CFG_IW-1:0] index;
    logic [31:0]           data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/gpe_param.sv */
`timescale 1ns / 1ps
`default_nettype none

module gpe_param import gpe_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    gpe_cfg_if.sink     cfg,
    output gpe_params_t prm
);

    typedef enum logic [2:0] {
        ST_PROD, ST_SEL, ST_DIVH, ST_DIVD, ST_RSTART, ST_RDIV, ST_IDLE
    } state_t;

    state_t      state_reg;
    logic [7:0]  z_reg;
    logic [31:0] h_reg, d_reg, hs_reg, ds_reg;
    logic [63:0] prod_reg, numd_reg, dnum_reg, dquo_reg;
    logic [55:0] ratio_reg;
    logic [31:0] dden_reg;
    logic [32:0] drem_reg;
    logic [5:0]  cnt_reg;
    gpe_lookup_t lk_reg;

    logic [32:0] rem_sh, rem_next;
    logic [63:0] quo_next, numh, numd;
    logic        take;

    assign cfg.ready = 1'b1;

    // one long-division step per cycle
    assign rem_sh   = {drem_reg[31:0], dnum_reg[63]};
    assign take     = rem_sh >= {1'b0, dden_reg};
    assign rem_next = take ? rem_sh - {1'b0, dden_reg} : rem_sh;
    assign quo_next = {dquo_reg[62:0], take};

    assign numh = 64'(lk_reg.h_lo) * 64'(lk_reg.wl) + 64'(lk_reg.h_hi) * 64'(lk_reg.wh)
                + 64'(lk_reg.span >> 1);
    assign numd = 64'(lk_reg.d_lo) * 64'(lk_reg.wl) + 64'(lk_reg.d_hi) * 64'(lk_reg.wh)
                + 64'(lk_reg.span >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PROD;
            z_reg     <= 8'd1;
            h_reg     <= '0;
            d_reg     <= '0;
            hs_reg    <= '0;
            ds_reg    <= '0;
            prod_reg  <= '0;
            numd_reg  <= '0;
            dnum_reg  <= '0;
            dquo_reg  <= '0;
            ratio_reg <= '0;
            dden_reg  <= '0;
            drem_reg  <= '0;
            cnt_reg   <= '0;
            lk_reg    <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                GPE_REG_Z: z_reg <= cfg.data[7:0];
                GPE_REG_H: h_reg <= cfg.data;
                GPE_REG_D: d_reg <= cfg.data;
                default: ;
            endcase
            state_reg <= ST_PROD;
        end
        else
        begin
            case (state_reg)
                ST_PROD:
                begin
                    prod_reg  <= 64'(h_reg) * 64'(d_reg);
                    lk_reg    <= gpe_lookup(z_reg);
                    state_reg <= ST_SEL;
                end
                ST_SEL:
                begin
                    if (prod_reg >= GPE_DEFAULT_LIMIT || z_reg < 8'd2)
                    begin
                        hs_reg    <= h_reg;
                        ds_reg    <= d_reg;
                        state_reg <= ST_RSTART;
                    end
                    else
                    begin
                        dnum_reg  <= numh;
                        numd_reg  <= numd;
                        dden_reg  <= 32'(lk_reg.span);
                        drem_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIVH;
                    end
                end
                ST_DIVH, ST_DIVD, ST_RDIV:
                begin
                    drem_reg <= rem_next;
                    dquo_reg <= quo_next;
                    dnum_reg <= dnum_reg << 1;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        case (state_reg)
                            ST_DIVH:
                            begin
                                hs_reg    <= quo_next[31:0];
                                dnum_reg  <= numd_reg;
                                drem_reg  <= '0;
                                cnt_reg   <= '0;
                                state_reg <= ST_DIVD;
                            end
                            ST_DIVD:
                            begin
                                ds_reg    <= quo_next[31:0];
                                state_reg <= ST_RSTART;
                            end
                            default:
                            begin
                                ratio_reg <= quo_next[55:0];
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_RSTART:
                begin
                    if (hs_reg == 32'd0)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        dnum_reg  <= {8'd0, ds_reg, 24'd0};
                        dden_reg  <= hs_reg;
                        drem_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_RDIV;
                    end
                end
                ST_IDLE: ;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign prm.busy   = state_reg != ST_IDLE;
    assign prm.h_zero = hs_reg == 32'd0;
    assign prm.d_zero = ds_reg == 32'd0;
    assign prm.z_neg  = z_reg == 8'd0;
    assign prm.z_mag  = (z_reg == 8'd0) ? 8'd1 : z_reg - 8'd1;
    assign prm.d      = ds_reg;
    assign prm.ratio  = ratio_reg;

endmodule

`default_nettype wire

/* src/gpe_pipe_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per stage; needs num < den << QW
module gpe_pipe_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int QW = 4,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [DW-1:0] rem,
    output logic [SW-1:0] side_out
);

    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic          v_reg    [QW];
    logic [WW-1:0] rem_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar g = 0; g < QW; g++)
    begin : g_step
        logic [WW-1:0] rem_in, trial;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_x;
        logic          v_in, take;

        if (g == 0)
        begin : g_first
            assign rem_in = WW'(num);
            assign quo_in = '0;
            assign den_in = den;
            assign side_x = side_in;
            assign v_in   = in_valid;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign den_in = den_reg[g-1];
            assign side_x = side_reg[g-1];
            assign v_in   = v_reg[g-1];
        end

        assign trial = WW'(den_in) << (QW - 1 - g);
        assign take  = rem_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (en)
                v_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= take ? rem_in - trial : rem_in;
                quo_reg[g]  <= {quo_in[QW-2:0], take};
                den_reg[g]  <= den_in;
                side_reg[g] <= side_x;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign rem       = rem_reg[QW-1][DW-1:0];
    assign side_out  = side_reg[QW-1];

endmodule

`default_nettype wire

/* src/gpe_phi.sv */
`timescale 1ns / 1ps
`default_nettype none

// (exp(f)-1)/f in Q32, Horner steps i = 13 .. 2, three stages per step
module gpe_phi import gpe_pkg::*; #(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   f_in,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [32:0]   ph,
    output logic [31:0]   f_out,
    output logic [SW-1:0] side_out
);

    localparam int NS = GPE_PHI_TOP - 1;

    logic          va_reg [NS], vb_reg [NS], vc_reg [NS];
    logic [32:0]   a_reg  [NS], ab_reg [NS], t_reg [NS];
    logic [68:0]   m_reg  [NS];
    logic [31:0]   fa_reg [NS], fb_reg [NS], fc_reg [NS];
    logic [SW-1:0] sa_reg [NS], sb_reg [NS], sc_reg [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_step
        localparam int DIV = GPE_PHI_TOP - s;
        localparam logic [35:0] RECIP = 36'((64'd1 << 35) / DIV);

        logic [32:0]   t_in;
        logic [31:0]   f_x;
        logic [SW-1:0] s_x;
        logic          v_x;
        logic [64:0]   p;
        logic [33:0]   q0, q;
        logic [34:0]   rr;

        if (s == 0)
        begin : g_first
            assign t_in = 33'd1 << 32;
            assign f_x  = f_in;
            assign s_x  = side_in;
            assign v_x  = in_valid;
        end
        else
        begin : g_rest
            assign t_in = t_reg[s-1];
            assign f_x  = fc_reg[s-1];
            assign s_x  = sc_reg[s-1];
            assign v_x  = vc_reg[s-1];
        end

        assign p  = t_in * f_x;
        // reciprocal quotient is low by at most one
        assign q0 = m_reg[s][68:35];
        assign rr = 35'(ab_reg[s]) - 35'(q0) * 35'(DIV);
        assign q  = (rr >= 35'(DIV)) ? q0 + 34'd1 : q0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[s] <= 1'b0;
                vb_reg[s] <= 1'b0;
                vc_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                va_reg[s] <= v_x;
                vb_reg[s] <= va_reg[s];
                vc_reg[s] <= vb_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[s]  <= p[64:32];
                fa_reg[s] <= f_x;
                sa_reg[s] <= s_x;
                m_reg[s]  <= a_reg[s] * RECIP;
                ab_reg[s] <= a_reg[s];
                fb_reg[s] <= fa_reg[s];
                sb_reg[s] <= sa_reg[s];
                t_reg[s]  <= (33'd1 << 32) + q[32:0];
                fc_reg[s] <= fb_reg[s];
                sc_reg[s] <= sb_reg[s];
            end
        end
    end

    assign out_valid = vc_reg[NS-1];
    assign ph        = t_reg[NS-1];
    assign f_out     = fc_reg[NS-1];
    assign side_out  = sc_reg[NS-1];

endmodule

`default_nettype wire

/* src/green_potential_evaluator_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Green parametric potential evaluator.
// cfg    : register writes (0 = Z, 1 = H Q8.24, 2 = d Q8.24), always ready.
//          Each write starts a parameter setup (default table, interpolation,
//          d/H ratio) on a serial divider, during which the sample channel
//          is held not ready.
// sample : one radius beat (unsigned Q8.24) per cycle outside setup and stalls.
// result : one beat per sample, potential (signed Q12.20) and saturated flag,
//          in order.
// Depth:  from sample accept to result valid the beat passes the pipelined
//          dividers (r/d 29 stages, ln2 range reduction 6, psi 33, final
//          quotient 32) and the Horner unit (12 steps of 3 stages).
// Throughput: one beat per cycle outside setup and result stalls.
// Reset sets Z = 1, H = d = 0 and runs one setup; all stages come up empty.
// Result stall: a two-beat output buffer sits after the pipeline; the pipeline
//   keeps moving while the buffer has room and freezes, losing nothing, while
//   it is full. result.ready never reaches sample.ready in the same cycle.
module green_potential_evaluator_top import gpe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    gpe_cfg_if.sink   cfg,
    gpe_in_if.sink    sample,
    gpe_out_if.source result
);

    typedef struct packed {
        logic        zero;
        logic        pz;
        logic [31:0] r;
    } side_r_t;

    typedef struct packed {
        logic        zero;
        logic        pz;
        logic [31:0] r;
        logic [28:0] x;
    } side_x_t;

    typedef struct packed {
        logic        zero;
        logic        pz;
        logic [31:0] r;
        logic [28:0] x;
        logic [5:0]  k;
    } side_k_t;

    gpe_params_t prm;

    gpe_param u_param (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .prm   (prm)
    );

    // pipeline advance: output buffer has room
    logic       en;
    logic [1:0] cnt_reg;

    assign en           = cnt_reg != 2'd2;
    assign sample.ready = en && !prm.busy;

    // input stage
    logic        v0_reg;
    logic [31:0] r0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= sample.valid && sample.ready;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            r0_reg <= sample.radius;
    end

    // x = r/d; psi is zero when d is zero or x reaches 32
    side_r_t s0;
    logic    big0;

    assign big0    = 37'(r0_reg) >= {prm.d, 5'd0};
    assign s0.zero = (r0_reg == 32'd0) || prm.h_zero;
    assign s0.pz   = big0 || prm.d_zero;
    assign s0.r    = r0_reg;

    logic        v1;
    logic [28:0] x1;
    side_r_t     s1;

    gpe_pipe_div #(.NW(56), .DW(32), .QW(29), .SW($bits(side_r_t))) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .num       (s0.pz ? 56'd0 : {r0_reg, 24'd0}),
        .den       (prm.d),
        .side_in   (s0),
        .out_valid (v1),
        .quo       (x1),
        .rem       (),
        .side_out  (s1)
    );

    // range reduction x = k*ln2 + f
    side_x_t     sx1;
    logic        v2;
    logic [5:0]  k2;
    logic [31:0] f2;
    side_x_t     s2;

    assign sx1 = '{zero: s1.zero, pz: s1.pz, r: s1.r, x: x1};

    gpe_pipe_div #(.NW(37), .DW(32), .QW(6), .SW($bits(side_x_t))) u_div_k (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1),
        .num       ({x1, 8'd0}),
        .den       (GPE_LN2_Q32),
        .side_in   (sx1),
        .out_valid (v2),
        .quo       (k2),
        .rem       (f2),
        .side_out  (s2)
    );

    side_k_t     sk2;
    logic        v3;
    logic [32:0] ph3;
    logic [31:0] f3;
    side_k_t     s3;

    assign sk2 = '{zero: s2.zero, pz: s2.pz, r: s2.r, x: s2.x, k: k2};

    gpe_phi #(.SW($bits(side_k_t))) u_phi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2),
        .f_in      (f2),
        .side_in   (sk2),
        .out_valid (v3),
        .ph        (ph3),
        .f_out     (f3),
        .side_out  (s3)
    );

    // e = 1 + phi*f (Q32)
    logic        ve_reg;
    logic [33:0] e_reg;
    logic [32:0] phe_reg;
    side_k_t     se_reg;
    logic [63:0] pf;

    assign pf = ph3[32:1] * f3;

    // psi operands: k = 0 divides all ones by phi, else x*2^(40-k) by e - 2^-k
    logic        vp_reg;
    logic [63:0] np_reg;
    logic [33:0] dp_reg;
    side_r_t     sp_reg;
    logic [60:0] n61;
    logic        kz;

    assign kz  = se_reg.k == 6'd0;
    assign n61 = (61'(se_reg.x) << 32) >> se_reg.k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
            vp_reg <= 1'b0;
        end
        else if (en)
        begin
            ve_reg <= v3;
            vp_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg   <= (34'd1 << 32) + 34'(pf >> 31);
            phe_reg <= ph3;
            se_reg  <= s3;
            np_reg  <= kz ? '1 : {n61[55:0], 8'd0};
            dp_reg  <= kz ? {1'b0, phe_reg} : e_reg - ((34'd1 << 32) >> se_reg.k);
            sp_reg  <= '{zero: se_reg.zero, pz: se_reg.pz, r: se_reg.r};
        end
    end

    logic        v4;
    logic [32:0] psi4;
    side_r_t     s4;

    gpe_pipe_div #(.NW(64), .DW(34), .QW(33), .SW($bits(side_r_t))) u_div_psi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vp_reg),
        .num       (np_reg),
        .den       (dp_reg),
        .side_in   (sp_reg),
        .out_valid (v4),
        .quo       (psi4),
        .rem       (),
        .side_out  (s4)
    );

    // q = ratio * psi, s = r + q, numerator = |Z-1|*2^44 + s/2
    logic [32:0] psi_m;
    logic        vq1_reg, vq2_reg, vq3_reg;
    logic [56:0] mhi_reg;
    logic [64:0] mlo_reg;
    logic [31:0] rq1_reg;
    logic        zq1_reg, zq2_reg, zq3_reg;
    logic [58:0] sq2_reg, sq3_reg;
    logic [59:0] num3, nq3_reg;
    logic        ovf3, ovq3_reg;

    assign psi_m = s4.pz ? 33'd0 : psi4;
    assign num3  = (60'(prm.z_mag) << 44) + 60'(sq2_reg >> 1);
    assign ovf3  = 91'(num3) >= {sq2_reg, 32'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq1_reg <= 1'b0;
            vq2_reg <= 1'b0;
            vq3_reg <= 1'b0;
        end
        else if (en)
        begin
            vq1_reg <= v4;
            vq2_reg <= vq1_reg;
            vq3_reg <= vq2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mhi_reg  <= prm.ratio[55:32] * psi_m;
            mlo_reg  <= prm.ratio[31:0] * psi_m;
            rq1_reg  <= s4.r;
            zq1_reg  <= s4.zero;
            sq2_reg  <= 59'(rq1_reg) + 59'(mhi_reg) + 59'(mlo_reg[64:32]);
            zq2_reg  <= zq1_reg;
            nq3_reg  <= ovf3 ? 60'd0 : num3;
            sq3_reg  <= sq2_reg;
            ovq3_reg <= ovf3;
            zq3_reg  <= zq2_reg;
        end
    end

    logic        v5;
    logic [31:0] vq5;
    logic [1:0]  s5;

    gpe_pipe_div #(.NW(60), .DW(59), .QW(32), .SW(2)) u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vq3_reg),
        .num       (nq3_reg),
        .den       (sq3_reg),
        .side_in   ({zq3_reg, ovq3_reg}),
        .out_valid (v5),
        .quo       (vq5),
        .rem       (),
        .side_out  (s5)
    );

    // sign and clipping
    logic [31:0] pot5;
    logic        sat5;

    always_comb
    begin
        pot5 = vq5;
        sat5 = 1'b0;
        if (s5[1])
            pot5 = 32'd0;
        else if (!prm.z_neg)
        begin
            if (s5[0] || vq5[31])
            begin
                pot5 = 32'h7FFF_FFFF;
                sat5 = 1'b1;
            end
        end
        else
        begin
            if (s5[0] || vq5 > 32'h8000_0000)
            begin
                pot5 = 32'h8000_0000;
                sat5 = 1'b1;
            end
            else
                pot5 = 32'd0 - vq5;
        end
    end

    // two-beat output buffer
    logic [31:0] pot_reg [2];
    logic        sat_reg [2];
    logic        wp_reg, rp_reg;
    logic        wr, rd;

    assign wr = v5 && en;
    assign rd = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            pot_reg[wp_reg] <= pot5;
            sat_reg[wp_reg] <= sat5;
        end
    end

    assign result.valid     = cnt_reg != 2'd0;
    assign result.potential = pot_reg[rp_reg];
    assign result.saturated = sat_reg[rp_reg];

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            result.potential == 32'h7FFF_FFFF || result.potential == 32'h8000_0000)
        else $error("saturated beat not at a bound");

    a_cfg_setup: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |=> prm.busy && !sample.ready)
        else $error("config write did not start parameter setup");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.potential))
        else $error("stalled result beat changed");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import gpe_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset, channels
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    gpe_cfg_if cfg ();
    gpe_in_if  sample ();
    gpe_out_if result ();

    green_potential_evaluator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .sample (sample.source),
        .result (result.sink)
    );

    // expected result of one radius beat
    typedef struct packed {
        logic [31:0] potential;
        logic        saturated;
    } potential_t;

    // index past the three registers; the block writes no register but restarts setup
    localparam logic [GPE_CFG_IW-1:0] REG_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // Shadow copy of the registers, updated on each accepted cfg beat
    // ------------------------------------------------------------------
    logic [7:0]  z_reg;
    logic [31:0] h_reg;
    logic [31:0] d_reg;

    // Default parameter table: Z, H and d as five-digit decimals.
    localparam int NTAB = 18;
    localparam int unsigned TZ [NTAB] = '{2, 3, 5, 11, 13, 19, 29, 31, 37, 47,
        49, 55, 70, 79, 81, 87, 102, 113};
    localparam int unsigned TH [NTAB] = '{1227500, 324800, 681200, 300100,
        983700, 555771, 250000, 293200, 479870, 195883, 336300, 584600, 370000,
        453331, 473540, 617300, 433716, 510036};
    localparam int unsigned TD [NTAB] = '{355200, 251800, 453500, 103800,
        299813, 165891, 65000, 73600, 106374, 52759, 75499, 114500, 66000,
        73931, 77490, 96700, 67213, 75391};

    localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;
    localparam logic [63:0] LN2 = 64'hB172_17F8;

    function automatic logic [63:0] dec_to_q24(input logic [63:0] v);
        return (v * 64'd16777216 + 64'd50000) / 64'd100000;
    endfunction

    // H and d after the default selection (table, interpolation, heavy atoms)
    function automatic void screening(output logic [63:0] h, output logic [63:0] d);
        logic [63:0] span, wl, wh;
        h = 64'(h_reg);
        d = 64'(d_reg);
        if (h * d >= 64'd281474977 || z_reg < 8'd2)
            return;
        if (z_reg > 8'd113) begin
            h = dec_to_q24(64'd500000);
            d = dec_to_q24(64'd75000);
            return;
        end
        for (int i = 0; i < NTAB; i++) begin
            if (TZ[i] == 32'(z_reg)) begin
                h = dec_to_q24(64'(TH[i]));
                d = dec_to_q24(64'(TD[i]));
                return;
            end
        end
        for (int i = 1; i < NTAB; i++) begin
            if (32'(z_reg) > TZ[i-1] && 32'(z_reg) < TZ[i]) begin
                span = 64'(TZ[i] - TZ[i-1]);
                wl   = 64'(TZ[i] - 32'(z_reg));
                wh   = 64'(32'(z_reg) - TZ[i-1]);
                h = (dec_to_q24(64'(TH[i-1])) * wl + dec_to_q24(64'(TH[i])) * wh
                     + span / 2) / span;
                d = (dec_to_q24(64'(TD[i-1])) * wl + dec_to_q24(64'(TD[i])) * wh
                     + span / 2) / span;
                return;
            end
        end
    endfunction

    // x/(exp(x)-1), x in Q8.24, result Q32
    function automatic logic [63:0] screen_fraction(input logic [63:0] x);
        logic [63:0] x32, k, f, t, e, den, n;
        x32 = x << 8;
        k = x32 / LN2;
        f = x32 - k * LN2;
        // (exp(f)-1)/f by Horner
        t = Q32_ONE;
        for (int i = 13; i >= 2; i--)
            t = Q32_ONE + ((t * f) >> 32) / 64'(i);
        if (k == 0)
            return 64'hFFFF_FFFF_FFFF_FFFF / t;
        e = Q32_ONE + (((t >> 1) * f) >> 31);
        den = e - (Q32_ONE >> k);
        n = (x << 32) >> k;
        return (n << 8) / den;
    endfunction

    function automatic potential_t green_potential(input logic [31:0] radius);
        potential_t  res;
        logic [63:0] r, h, d, psi, ratio, q, s, mag, v, x;
        logic [8:0]  zm;
        logic        neg;
        res = '0;
        r = 64'(radius);
        if (r == 0)
            return res;
        screening(h, d);
        if (h == 0)
            return res;
        psi = 0;
        if (d != 0) begin
            x = (r << 24) / d;
            if (x < (64'd32 << 24))
                psi = screen_fraction(x);
        end
        ratio = (d << 24) / h;
        q = (ratio >> 32) * psi + (((ratio & 64'hFFFF_FFFF) * psi) >> 32);
        s = r + q;
        neg = (z_reg == 8'd0);
        zm  = neg ? 9'd1 : 9'(z_reg) - 9'd1;
        mag = 64'(zm) << 44;
        v = (mag + s / 2) / s;
        if (!neg) begin
            if (v > 64'h7FFF_FFFF) begin
                v = 64'h7FFF_FFFF;
                res.saturated = 1'b1;
            end
            res.potential = v[31:0];
        end else begin
            if (v > 64'h8000_0000) begin
                v = 64'h8000_0000;
                res.saturated = 1'b1;
            end
            res.potential = 32'(64'd0 - v);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    logic [31:0] radius_backlog[$];   // radii waiting for the driver
    potential_t  expected_q[$];       // predictions, oldest first
    int          in_flight = 0;       // pushed radii without a checked result
    int          errors = 0;
    bit          tx_steady = 1'b0;    // no source gaps when set
    bit          rx_steady = 1'b0;    // no sink stalls when set
    int          hold_ask = 0;        // bump to request a long result stall

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    // short gaps mostly, long ones now and then
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds radius beats from the backlog, predicts on accept
    // ------------------------------------------------------------------
    int tx_gap;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sample.valid  <= 1'b0;
            sample.radius <= '0;
            tx_gap        <= 0;
        end else begin
            if (sample.valid && sample.ready)
                expected_q = {expected_q, green_potential(sample.radius)};
            if (sample.valid && !sample.ready) begin
                // hold the beat
            end else if (tx_gap > 0 && !tx_steady) begin
                tx_gap       <= tx_gap - 1;
                sample.valid <= 1'b0;
            end else if (radius_backlog.size() > 0) begin
                sample.radius <= radius_backlog.pop_front();
                sample.valid  <= 1'b1;
                tx_gap        <= pick_gap();
            end else begin
                sample.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long result stall, counted in cycles
    // ------------------------------------------------------------------
    int hold_left;
    int hold_seen;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_ask != hold_seen) begin
            // long stall so the pipeline backs up into the sample channel
            hold_seen <= hold_ask;
            hold_left <= 600;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result beat, drives result.ready
    // ------------------------------------------------------------------
    int rx_gap;
    potential_t want;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result.ready <= 1'b0;
            rx_gap       <= 0;
        end else begin
            if (result.valid && result.ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected beat", result.potential, 32'hx);
                end else begin
                    want = expected_q.pop_front();
                    in_flight--;
                    if (result.potential !== want.potential)
                        report("potential", result.potential, want.potential);
                    if (result.saturated !== want.saturated)
                        report("saturated", 32'(result.saturated), 32'(want.saturated));
                end
            end
            if (hold_left > 0) begin
                result.ready <= 1'b0;
            end else if (rx_gap > 0 && !rx_steady) begin
                rx_gap       <= rx_gap - 1;
                result.ready <= 1'b0;
            end else begin
                result.ready <= 1'b1;
                if (result.valid && result.ready)
                    rx_gap <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_radius(input logic [31:0] r);
        in_flight++;
        radius_backlog = {radius_backlog, r};
    endtask

    // wait until the block has drained every result
    task automatic wait_drained();
        do @(posedge clk); while (in_flight != 0);
    endtask

    // one register beat; valid is left high, the caller lowers it
    task automatic reg_write(input logic [GPE_CFG_IW-1:0] idx, input logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            GPE_REG_Z: z_reg = val[7:0];
            GPE_REG_H: h_reg = val;
            GPE_REG_D: d_reg = val;
            default: ;  // unused index, no register written by the block, but setup restarts
        endcase
    endtask

    task automatic setup(input logic [7:0] z, input logic [31:0] h, input logic [31:0] d);
        wait_drained();
        reg_write(GPE_REG_Z, 32'(z));
        reg_write(GPE_REG_H, h);
        reg_write(GPE_REG_D, d);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_radius();
        int p;
        p = $urandom_range(0, 99);
        if (p < 3) return 32'd0;
        if (p < 45) return $urandom();
        if (p < 90) return $urandom_range(1, 32'h0800_0000);
        return $urandom_range(1, 32'h0000_1000);
    endfunction

    function automatic logic [31:0] pick_param();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4) return $urandom_range(32'h0010_0000, 32'h0800_0000);
        if (p < 7) return $urandom();
        if (p < 8) return 32'hFFFF_FFFF;
        return $urandom_range(0, 32'h0000_00FF);
    endfunction

    function automatic logic [7:0] pick_z();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 8'd0;
        if (p == 1) return 8'd1;
        if (p < 4) return 8'(TZ[$urandom_range(0, NTAB-1)]);
        if (p < 8) return 8'($urandom_range(2, 113));
        return 8'($urandom_range(114, 255));
    endfunction

    task automatic directed_radii();
        push_radius(32'd0);
        push_radius(32'd1);
        push_radius(32'hFFFF_FFFF);
    endtask

    initial begin
        logic [31:0] h, d;
        int n;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        z_reg = 8'd1;
        h_reg = '0;
        d_reg = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: Z = 1 gives zero everywhere
        directed_radii();
        push_radius(32'h0100_0000);
        // Z = 0 with negligible q: negative clip at the smallest nonzero radius
        setup(8'd0, 32'hFFFF_FFFF, 32'd1);
        directed_radii();
        // heavy atom on defaults: positive potential, below the clip
        setup(8'd255, 32'd0, 32'd0);
        directed_radii();
        // exact table entry, then interpolated
        setup(8'd2, 32'd0, 32'd0);
        directed_radii();
        push_radius(32'h0100_0000);
        setup(8'd4, 32'd0, 32'd0);
        directed_radii();
        // zero length kept below Z = 2
        setup(8'd0, 32'h0100_0000, 32'd0);
        directed_radii();
        // zero height kept below Z = 2
        setup(8'd0, 32'd0, 32'h0100_0000);
        directed_radii();
        // top of table with all-ones parameters, plus a write to the unused index
        wait_drained();
        reg_write(GPE_REG_Z, 32'd113);
        reg_write(GPE_REG_H, 32'hFFFF_FFFF);
        reg_write(GPE_REG_D, 32'hFFFF_FFFF);
        reg_write(REG_UNUSED, 32'hDEAD_BEEF);
        cfg.valid <= 1'b0;
        directed_radii();
        push_radius(32'hAAAA_AAAA);
        push_radius(32'h5555_5555);

        // random settings and radii
        for (int ph = 0; ph < 12; ph++) begin
            if ($urandom_range(0, 2) == 0) begin
                h = 32'd0;
                d = 32'd0;
            end else begin
                h = pick_param();
                d = pick_param();
            end
            setup(pick_z(), h, d);
            tx_steady = (ph % 4 == 1);
            rx_steady = (ph % 4 == 2);
            n = 40;
            if (ph == 5) begin
                // back pressure: more beats than the pipeline holds, long sink stall
                tx_steady = 1'b1;
                n = 230;
                hold_ask++;
            end
            for (int i = 0; i < n; i++)
                push_radius(pick_radius());
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
